FILE: rtl/core/hhc_pkg.sv
// shared types and constants of the hashed hot-spot counter
package hhc_pkg;

    // table size must be a power of two: the slot is the low bits of the key
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = 16;
    localparam int KEY_W         = 32;
    localparam int ENTRY_W       = 6;
    localparam int REQ_W         = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int THR_W         = 16;

    localparam int NUM_TABLES    = 3;
    localparam int TBL_LOOP      = 0;
    localparam int TBL_CALL      = 1;
    localparam int TBL_EXIT      = 2;

    localparam logic [THR_W-1:0] LOOP_THR_RESET = 16'd56;
    localparam logic [THR_W-1:0] CALL_THR_RESET = 16'd112;
    localparam logic [THR_W-1:0] EXIT_THR_RESET = 16'd10;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOP  = 2'd0,
        REQ_CALL  = 2'd1,
        REQ_EXIT  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOOP_THR = 2'd0,
        CFG_CALL_THR = 2'd1,
        CFG_EXIT_THR = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [THR_W-1:0] loop_thr;
        logic [THR_W-1:0] call_thr;
        logic [THR_W-1:0] exit_thr;
    } hhc_thr_t;

endpackage

FILE: rtl/core/hhc_if.sv
// request, result and configuration channel interfaces
interface hhc_req_if;
    import hhc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [KEY_W-1:0]     key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface hhc_res_if;
    import hhc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 hot;
    logic [ENTRY_W-1:0]   entry_index;

    modport source (output valid, output hot, output entry_index, input ready);
    modport sink   (input valid, input hot, input entry_index, output ready);
endinterface

interface hhc_cfg_if;
    import hhc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/hhc_ram.sv
// generic single-port-write ram with registered read
module hhc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/hhc_cfg.sv
// threshold configuration registers
module hhc_cfg (
    input  logic            clk,
    input  logic            rst_n,
    hhc_cfg_if.sink         cfg,
    output hhc_pkg::hhc_thr_t thr
);
    import hhc_pkg::*;

    hhc_thr_t thr_reg;

    assign cfg.ready = 1'b1;
    assign thr       = thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.loop_thr <= LOOP_THR_RESET;
            thr_reg.call_thr <= CALL_THR_RESET;
            thr_reg.exit_thr <= EXIT_THR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LOOP_THR: thr_reg.loop_thr <= cfg.data;
                CFG_CALL_THR: thr_reg.call_thr <= cfg.data;
                CFG_EXIT_THR: thr_reg.exit_thr <= cfg.data;
                default:      thr_reg <= thr_reg;
            endcase
        end
    end

endmodule

FILE: rtl/core/hashed_hot_spot_counter_top.sv
// hashed hot-spot counter top level
// throughput: one request per cycle while the result side is not stalled; the counter
//   ram read-modify-write closes with a one-entry write forward
// reset: thresholds to defaults, all counters read as zero via per-entry valid bits
module hashed_hot_spot_counter_top (
    input  logic        clk,
    input  logic        rst_n,
    hhc_req_if.sink     req,
    hhc_res_if.source   res,
    hhc_cfg_if.sink     cfg
);
    import hhc_pkg::*;

    hhc_thr_t                              thr;

    logic                                  s1_valid_reg;
    req_type_t                             s1_type_reg;
    logic [IDX_W-1:0]                      s1_slot_reg;

    logic                                  out_valid_reg;
    logic                                  out_hot_reg;
    logic [ENTRY_W-1:0]                    out_index_reg;

    logic                                  fwd_valid_reg;
    req_type_t                             fwd_type_reg;
    logic [IDX_W-1:0]                      fwd_slot_reg;
    logic [CNT_W-1:0]                      fwd_data_reg;

    logic [NUM_TABLES-1:0][TABLE_ENTRIES-1:0] vld_reg;

    logic [CNT_W-1:0]                      ram_q [NUM_TABLES];
    logic [NUM_TABLES-1:0]                 tbl_we;

    logic                                  accept;
    logic                                  s1_advance;
    logic                                  is_clear;
    logic                                  fwd_hit;
    logic                                  sel_vld;
    logic                                  cnt_hot;
    logic [CNT_W-1:0]                      sel_q;
    logic [THR_W-1:0]                      sel_thr;
    logic [CNT_W-1:0]                      cur_cnt;
    logic [CNT_W-1:0]                      nxt_cnt;
    logic [CNT_W-1:0]                      wr_cnt;

    hhc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .thr   (thr)
    );

    assign s1_advance = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign accept     = req.valid && req.ready;
    assign is_clear   = (s1_type_reg == REQ_CLEAR);

    for (genvar t = 0; t < NUM_TABLES; t++)
    begin : g_tbl
        assign tbl_we[t] = s1_advance && (s1_type_reg == req_type_t'(REQ_W'(t)));

        hhc_ram #(
            .WIDTH (CNT_W),
            .DEPTH (TABLE_ENTRIES)
        ) u_ram (
            .clk   (clk),
            .we    (tbl_we[t]),
            .waddr (s1_slot_reg),
            .wdata (wr_cnt),
            .re    (accept),
            .raddr (req.key[IDX_W-1:0]),
            .rdata (ram_q[t])
        );
    end

    always_comb
    begin
        case (s1_type_reg)
            REQ_LOOP:
            begin
                sel_q   = ram_q[TBL_LOOP];
                sel_thr = thr.loop_thr;
                sel_vld = vld_reg[TBL_LOOP][s1_slot_reg];
            end
            REQ_CALL:
            begin
                sel_q   = ram_q[TBL_CALL];
                sel_thr = thr.call_thr;
                sel_vld = vld_reg[TBL_CALL][s1_slot_reg];
            end
            REQ_EXIT:
            begin
                sel_q   = ram_q[TBL_EXIT];
                sel_thr = thr.exit_thr;
                sel_vld = vld_reg[TBL_EXIT][s1_slot_reg];
            end
            default:
            begin
                sel_q   = '0;
                sel_thr = '0;
                sel_vld = 1'b0;
            end
        endcase
    end

    // latest write may not be visible in the ram read yet
    assign fwd_hit = fwd_valid_reg && (fwd_type_reg == s1_type_reg)
                     && (fwd_slot_reg == s1_slot_reg);

    assign cur_cnt = !sel_vld ? '0 : (fwd_hit ? fwd_data_reg : sel_q);
    assign nxt_cnt = cur_cnt + CNT_W'(1);
    assign cnt_hot = (nxt_cnt >= sel_thr);
    assign wr_cnt  = cnt_hot ? '0 : nxt_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                fwd_valid_reg <= !is_clear;
            end

            if (s1_advance && is_clear)
            begin
                vld_reg <= '0;
            end
            else
            begin
                for (int t = 0; t < NUM_TABLES; t++)
                begin
                    if (tbl_we[t])
                    begin
                        vld_reg[t][s1_slot_reg] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg <= req_type_t'(req.req_type);
            s1_slot_reg <= req.key[IDX_W-1:0];
        end
        if (s1_advance)
        begin
            fwd_type_reg  <= s1_type_reg;
            fwd_slot_reg  <= s1_slot_reg;
            fwd_data_reg  <= wr_cnt;
            out_hot_reg   <= is_clear ? 1'b0 : cnt_hot;
            out_index_reg <= is_clear ? '0 : ENTRY_W'(s1_slot_reg);
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.hot         = out_hot_reg;
    assign res.entry_index = out_index_reg;

`ifndef SYNTHESIS
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("stage advanced without loading the result register");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_slot_reg)))
        else $error("stalled request left the stage");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && is_clear) |=> (vld_reg == '0 && !fwd_valid_reg))
        else $error("clear request left live counters");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && is_clear) |=> (!out_hot_reg && out_index_reg == '0))
        else $error("clear request produced a nonzero result");
`endif

endmodule

FILE: tb/tb_hashed_hot_spot_counter_top.sv
// testbench of the hashed hot-spot counter: paced requests checked against a counter-table model
`timescale 1ns / 100ps

module tb_hashed_hot_spot_counter_top;
    import hhc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        req_type_t          kind;
        logic [KEY_W-1:0]   key;
    } hit_request_t;

    typedef struct packed {
        logic               hot;
        logic [ENTRY_W-1:0] entry;
    } hot_report_t;

    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        logic [THR_W-1:0]     data;
    } threshold_write_t;

    logic clk;
    logic rst_n;

    hhc_req_if req_ch();
    hhc_res_if res_ch();
    hhc_cfg_if cfg_ch();

    hashed_hot_spot_counter_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    hit_request_t     pending_requests[$];
    hot_report_t      expected_reports[$];
    threshold_write_t threshold_writes[$];

    logic [CNT_W-1:0] hit_count [NUM_TABLES][TABLE_ENTRIES];
    logic [THR_W-1:0] hot_limit [NUM_TABLES];

    int  pushed_requests;
    int  accepted_requests;
    int  failures;
    int  idle_cycles;
    int  req_gap;
    int  ready_hold;
    bit  req_taken;
    bit  gaps_on;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        k = $urandom();
        if ($urandom_range(0, 9) < 7)
            k[IDX_W-1:0] = IDX_W'($urandom_range(0, 5));
        return k;
    endfunction

    function automatic logic [THR_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return THR_W'(1);
            2: return '1;
            3: return THR_W'($urandom());
            default: return THR_W'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic hot_report_t predict_report(input req_type_t kind,
                                                   input logic [KEY_W-1:0] key);
        hot_report_t      rep;
        int               tbl;
        logic [IDX_W-1:0] slot;
        logic [CNT_W-1:0] next_count;
        slot      = key[IDX_W-1:0];
        rep.hot   = 1'b0;
        rep.entry = ENTRY_W'(slot);
        case (kind)
            REQ_LOOP:  tbl = TBL_LOOP;
            REQ_CALL:  tbl = TBL_CALL;
            REQ_EXIT:  tbl = TBL_EXIT;
            default:   tbl = -1;
        endcase
        if (tbl < 0)
        begin
            for (int t = 0; t < NUM_TABLES; t++)
                for (int e = 0; e < TABLE_ENTRIES; e++)
                    hit_count[t][e] = '0;
            rep.entry = '0;
        end
        else
        begin
            next_count = hit_count[tbl][slot] + 1'b1;
            if (next_count >= hot_limit[tbl])
            begin
                hit_count[tbl][slot] = '0;
                rep.hot = 1'b1;
            end
            else
                hit_count[tbl][slot] = next_count;
        end
        return rep;
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic queue_request(input req_type_t kind, input logic [KEY_W-1:0] key);
        hit_request_t item;
        item.kind = kind;
        item.key  = key;
        pending_requests.push_back(item);
        pushed_requests++;
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] index, input logic [THR_W-1:0] data);
        threshold_write_t w;
        w.index = index;
        w.data  = data;
        threshold_writes.push_back(w);
    endtask

    task automatic program_thresholds();
        threshold_write_t w;
        while (threshold_writes.size() != 0)
        begin
            w = threshold_writes.pop_front();
            @(negedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= w.index;
            cfg_ch.data  <= w.data;
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (accepted_requests != pushed_requests || expected_reports.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                queue_request(REQ_CLEAR, $urandom());
            else
                queue_request(req_type_t'($urandom_range(0, 2)), pick_key());
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // request driver
    always @(negedge clk)
    begin : request_driver
        hit_request_t item;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_taken)
        begin
            if (req_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                req_gap <= req_gap - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                item = pending_requests.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= item.kind;
                req_ch.key      <= item.key;
                req_gap         <= pick_gap();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (ready_hold > 0)
        begin
            res_ch.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin : result_monitor
        hot_report_t want;
        bit          moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                moved = 1'b1;
                case (cfg_ch.index)
                    CFG_LOOP_THR: hot_limit[TBL_LOOP] = cfg_ch.data;
                    CFG_CALL_THR: hot_limit[TBL_CALL] = cfg_ch.data;
                    CFG_EXIT_THR: hot_limit[TBL_EXIT] = cfg_ch.data;
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready)
            begin
                moved = 1'b1;
                if (expected_reports.size() == 0)
                    report_failure($sformatf("unexpected result hot=%0d entry=%0d",
                                             res_ch.hot, res_ch.entry_index));
                else
                begin
                    want = expected_reports.pop_front();
                    if (res_ch.hot !== want.hot || res_ch.entry_index !== want.entry)
                        report_failure($sformatf(
                            "mismatch: hot exp %0d got %0d, entry exp %0d got %0d",
                            want.hot, res_ch.hot, want.entry, res_ch.entry_index));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                expected_reports.push_back(
                    predict_report(req_type_t'(req_ch.req_type), req_ch.key));
                accepted_requests++;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [KEY_W-1:0] k;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_LOOP;
        req_ch.key      = '0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_LOOP_THR;
        cfg_ch.data     = '0;
        req_taken       = 1'b0;
        req_gap         = 0;
        ready_hold      = 0;
        idle_cycles     = 0;
        failures        = 0;
        pushed_requests = 0;
        accepted_requests = 0;
        gaps_on         = 1'b1;
        hot_limit[TBL_LOOP] = LOOP_THR_RESET;
        hot_limit[TBL_CALL] = CALL_THR_RESET;
        hot_limit[TBL_EXIT] = EXIT_THR_RESET;
        for (int t = 0; t < NUM_TABLES; t++)
            for (int e = 0; e < TABLE_ENTRIES; e++)
                hit_count[t][e] = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default thresholds, key extremes, slot aliasing, clear
        queue_request(REQ_LOOP, '0);
        queue_request(REQ_LOOP, '1);
        queue_request(REQ_CALL, 32'h8000_003F);
        queue_request(REQ_EXIT, 32'h0000_0040);
        queue_request(REQ_CLEAR, '1);
        for (int i = 0; i < 10; i++)
        begin
            k = $urandom();
            k[IDX_W-1:0] = IDX_W'(5);
            queue_request(REQ_EXIT, k);
        end
        wait_until_drained();

        // zero and one thresholds report every hit, max threshold does not, spare index ignored
        add_write(CFG_LOOP_THR, '0);
        add_write(CFG_CALL_THR, THR_W'(1));
        add_write(CFG_EXIT_THR, '1);
        add_write(CFG_SPARE, THR_W'($urandom()));
        program_thresholds();
        queue_request(REQ_LOOP, 32'h1234_5678);
        queue_request(REQ_CALL, 32'hDEAD_BEEF);
        queue_request(REQ_EXIT, 32'h0000_0007);
        queue_request(REQ_EXIT, 32'hFFFF_FFC7);
        queue_request(REQ_CALL, 32'h0000_0000);
        wait_until_drained();

        // threshold lowered below a stored count
        add_write(CFG_LOOP_THR, '1);
        program_thresholds();
        for (int i = 0; i < 40; i++)
        begin
            k = $urandom();
            k[IDX_W-1:0] = IDX_W'(9);
            queue_request(REQ_LOOP, k);
        end
        wait_until_drained();
        add_write(CFG_LOOP_THR, THR_W'(3));
        program_thresholds();
        k = $urandom();
        k[IDX_W-1:0] = IDX_W'(9);
        queue_request(REQ_LOOP, k);
        wait_until_drained();

        for (int p = 0; p < 10; p++)
        begin
            gaps_on = (p % 3 != 2);
            add_write(CFG_EXIT_THR, pick_threshold());
            add_write(CFG_LOOP_THR, pick_threshold());
            add_write(CFG_CALL_THR, pick_threshold());
            if ($urandom_range(0, 3) == 0)
                add_write(CFG_SPARE, THR_W'($urandom()));
            program_thresholds();
            run_random_phase(90);
            wait_until_drained();
        end

        repeat (6) @(posedge clk);
        if (failures == 0 && expected_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
